// ===== hdl/acre_pkg.sv =====
`default_nettype none

package acre_pkg;

	// Default widths of the clip inputs and of the run counter.
	localparam int READ_LENGTH_BITS_DEF = 16;
	localparam int RUN_COUNT_BITS_DEF   = 28;

	localparam int WORD_W    = 32;
	localparam int OP_W      = 4;
	localparam int BASE_W    = 8;
	localparam int CLIP_W    = 16;
	localparam int SLOTS     = 3;
	localparam int SLOT_IDX_W = 2;

	localparam logic [BASE_W-1:0] GAP_CHAR = 8'd45;

	// Operation codes of a packed CIGAR word.
	typedef enum logic [OP_W-1:0] {
		OP_M = 4'd0,
		OP_I = 4'd1,
		OP_D = 4'd2,
		OP_S = 4'd4
	} cigar_op_t;

	// Kind of the run that is in progress.
	typedef enum logic [1:0] {
		RUN_M = 2'd0,
		RUN_I = 2'd1,
		RUN_D = 2'd2
	} run_op_t;

	// All words that one column causes, in output order.
	typedef struct packed {
		logic [SLOTS-1:0][WORD_W-1:0] words;
		logic [SLOT_IDX_W-1:0]        count;
		logic                         fin;
	} acre_bundle_t;

endpackage

`default_nettype wire

// ===== hdl/acre_front.sv =====
`default_nettype none

module acre_front #(
	parameter int READ_LENGTH_BITS = acre_pkg::READ_LENGTH_BITS_DEF,
	parameter int RUN_COUNT_BITS   = acre_pkg::RUN_COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [acre_pkg::BASE_W-1:0] ref_base,
	input  wire logic [acre_pkg::BASE_W-1:0] query_base,
	input  wire logic                        first_column,
	input  wire logic                        last_column,
	input  wire logic                        empty_alignment,
	input  wire logic [acre_pkg::CLIP_W-1:0] clip_begin,
	input  wire logic [acre_pkg::CLIP_W-1:0] clip_end,
	input  wire logic [acre_pkg::CLIP_W-1:0] total_read_length,
	input  wire logic                        q_full,
	output logic                             push,
	output acre_pkg::acre_bundle_t           bundle
);
	import acre_pkg::*;

	localparam int RLB = READ_LENGTH_BITS;
	localparam int RCB = RUN_COUNT_BITS;

	run_op_t          run_op_q;
	logic [RCB-1:0]   run_count_q;
	logic             run_open_q;

	logic [27:0]      cbeg_ext, cend_ext, rlen_ext;
	logic [RLB-1:0]   cbeg, cend, rlen;
	logic [RLB:0]     cend_p1;
	logic             rgap, qgap;
	logic             cur_open;
	run_op_t          cur_op;
	logic [RCB-1:0]   cur_cnt;
	logic             extend;
	run_op_t          nxt_op;
	logic [RCB-1:0]   nxt_cnt;
	logic             va, vb, vc;
	logic [WORD_W-1:0] wa, wb, wc;
	logic             accept;

	assign cbeg_ext = 28'(clip_begin);
	assign cend_ext = 28'(clip_end);
	assign rlen_ext = 28'(total_read_length);
	assign cbeg     = cbeg_ext[RLB-1:0];
	assign cend     = cend_ext[RLB-1:0];
	assign rlen     = rlen_ext[RLB-1:0];
	assign cend_p1  = {1'b0, cend} + (RLB+1)'(1);

	assign rgap = (ref_base == GAP_CHAR);
	assign qgap = (query_base == GAP_CHAR);

	// A first column drops whatever run is still open.
	assign cur_open = run_open_q && !first_column;
	assign cur_op   = first_column ? RUN_M : run_op_q;
	assign cur_cnt  = first_column ? '0 : run_count_q;

	always_comb begin
		extend = 1'b0;
		if (cur_open) begin
			case (cur_op)
				RUN_M:   extend = !rgap && !qgap;
				RUN_I:   extend = rgap;
				RUN_D:   extend = qgap;
				default: extend = qgap;
			endcase
		end
	end

	always_comb begin
		if (extend) begin
			nxt_op  = cur_op;
			nxt_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + RCB'(1);
		end else begin
			nxt_op  = rgap ? RUN_I : (qgap ? RUN_D : RUN_M);
			nxt_cnt = RCB'(1);
		end
	end

	// Candidate words: leading clip or closed run, last run, trailing clip, or one whole-read clip.
	always_comb begin
		va = 1'b0;
		wa = '0;
		vb = 1'b0;
		wb = '0;
		vc = 1'b0;
		wc = '0;
		if (empty_alignment) begin
			va = 1'b1;
			wa = WORD_W'({rlen, OP_S});
		end else begin
			if (first_column && (cbeg != '0)) begin
				va = 1'b1;
				wa = WORD_W'({cbeg, OP_S});
			end else if (cur_open && !extend) begin
				va = 1'b1;
				wa = WORD_W'({cur_cnt, 2'b00, cur_op});
			end
			vb = last_column;
			wb = WORD_W'({nxt_cnt, 2'b00, nxt_op});
			vc = last_column && ({1'b0, rlen} > cend_p1);
			wc = WORD_W'({rlen - cend_p1[RLB-1:0], OP_S});
		end
	end

	always_comb begin
		bundle.words[0] = va ? wa : (vb ? wb : wc);
		bundle.words[1] = va ? (vb ? wb : wc) : wc;
		bundle.words[2] = wc;
		bundle.count    = SLOT_IDX_W'(va) + SLOT_IDX_W'(vb) + SLOT_IDX_W'(vc);
		bundle.fin      = empty_alignment || last_column;
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (bundle.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_op_q    <= RUN_M;
			run_count_q <= '0;
			run_open_q  <= 1'b0;
		end else if (accept) begin
			if (empty_alignment || last_column) begin
				run_op_q    <= RUN_M;
				run_count_q <= '0;
				run_open_q  <= 1'b0;
			end else begin
				run_op_q    <= nxt_op;
				run_count_q <= nxt_cnt;
				run_open_q  <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/acre_queue.sv =====
`default_nettype none

module acre_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire acre_pkg::acre_bundle_t push_data,
	output logic                        full,
	input  wire logic                   pop,
	output logic                        not_empty,
	output acre_pkg::acre_bundle_t      head
);
	import acre_pkg::*;

	acre_bundle_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/acre_back.sv =====
`default_nettype none

module acre_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_not_empty,
	input  wire acre_pkg::acre_bundle_t      q_head,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [acre_pkg::WORD_W-1:0]      cigar_word,
	output logic                             final_word,
	output logic                             last_of_item
);
	import acre_pkg::*;

	acre_bundle_t          hold_q;
	logic                  hold_valid_q;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic                  at_last;
	logic                  take;

	assign at_last      = (idx_q == hold_q.count - SLOT_IDX_W'(1));
	assign out_valid    = hold_valid_q;
	assign cigar_word   = hold_q.words[idx_q];
	assign last_of_item = at_last;
	assign final_word   = at_last && hold_q.fin;

	assign take  = hold_valid_q && out_ready;
	assign q_pop = q_not_empty && (!hold_valid_q || (take && at_last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hold_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			idx_q        <= '0;
		end else if (q_pop) begin
			hold_valid_q <= 1'b1;
			idx_q        <= '0;
		end else if (take) begin
			if (at_last) begin
				hold_valid_q <= 1'b0;
				idx_q        <= '0;
			end else begin
				idx_q <= idx_q + SLOT_IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/alignment_cigar_run_encoder_unit.sv =====
`default_nettype none

// Streaming BAM CIGAR encoder. Each input word is one alignment column (reference
// and query byte, '-' being a gap) plus first, last and empty-alignment flags and
// the clip bounds; each output word is one packed CIGAR entry, length << 4 | op,
// with M=0, I=1, D=2, S=4, flagged with final_word on the last entry of an
// alignment and last_of_item on the last entry caused by a column. The front end
// takes one column per cycle while its queue is not full, updates the open run and
// builds the words the column causes, up to three; these sit in a two-entry queue
// and the back end sends them one per cycle through a registered output while the
// receiver is ready. The sustained rate is one column per cycle as long as the
// columns average at most one output word each; the single output word per cycle
// is what limits it otherwise. Columns that only extend a run produce no output.
module alignment_cigar_run_encoder_unit #(
	parameter int READ_LENGTH_BITS = acre_pkg::READ_LENGTH_BITS_DEF,
	parameter int RUN_COUNT_BITS   = acre_pkg::RUN_COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [acre_pkg::BASE_W-1:0] ref_base,
	input  wire logic [acre_pkg::BASE_W-1:0] query_base,
	input  wire logic                        first_column,
	input  wire logic                        last_column,
	input  wire logic                        empty_alignment,
	input  wire logic [acre_pkg::CLIP_W-1:0] clip_begin,
	input  wire logic [acre_pkg::CLIP_W-1:0] clip_end,
	input  wire logic [acre_pkg::CLIP_W-1:0] total_read_length,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [acre_pkg::WORD_W-1:0]      cigar_word,
	output logic                             final_word,
	output logic                             last_of_item
);
	import acre_pkg::*;

	// Words built by the front end for one column, and the queue handshake.
	acre_bundle_t push_bundle;
	acre_bundle_t head_bundle;
	logic         push;
	logic         q_full;
	logic         q_not_empty;
	logic         q_pop;

	// The front end holds the open run and classifies every column: it decides
	// whether the column extends the run or closes it, and adds the soft clips.
	acre_front #(
		.READ_LENGTH_BITS(READ_LENGTH_BITS),
		.RUN_COUNT_BITS  (RUN_COUNT_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.ref_base         (ref_base),
		.query_base       (query_base),
		.first_column     (first_column),
		.last_column      (last_column),
		.empty_alignment  (empty_alignment),
		.clip_begin       (clip_begin),
		.clip_end         (clip_end),
		.total_read_length(total_read_length),
		.q_full           (q_full),
		.push             (push),
		.bundle           (push_bundle)
	);

	// The queue lets the input keep flowing while the output side is stalled.
	acre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_bundle),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (head_bundle)
	);

	// The back end sends the queued words one at a time and tags the last ones.
	acre_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (head_bundle),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cigar_word  (cigar_word),
		.final_word  (final_word),
		.last_of_item(last_of_item)
	);

endmodule

`default_nettype wire

// ===== test/tb_alignment_cigar_run_encoder_unit.sv =====
`default_nettype none

module tb_alignment_cigar_run_encoder_unit;
	import acre_pkg::*;

	// Generous bound on the whole run, allowing for three words per column, each
	// behind the longest random receiver stall.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Length of the long receiver hold-off that fills the block.
	localparam int unsigned HOLD_CYCLES = 300;
	// Cycles to wait after the last expected word, for stray output.
	localparam int unsigned DRAIN_CYCLES = 32;

	// Shape of one column: which bytes carry a gap.
	typedef enum logic [1:0] {
		COL_MATCH,
		COL_INS,
		COL_DEL,
		COL_BOTH_GAP
	} col_kind_t;

	// One expected CIGAR word together with its two flags.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              fin;
		logic              tail;
	} cigar_entry_t;

	// The scoreboard keeps its own copy of the open run. Every accepted column
	// is turned into the words the encoder must send for it, and every word
	// the encoder sends is checked against the oldest of those.
	class cigar_scoreboard;
		cigar_entry_t pending_words[$];
		cigar_entry_t fresh_words[$];
		run_op_t      open_op;
		int unsigned  open_len;
		bit           open_run;
		int unsigned  mismatches;

		function new();
			clear_run();
			mismatches = 0;
		endfunction

		function void clear_run();
			open_op  = RUN_M;
			open_len = 0;
			open_run = 1'b0;
		endfunction

		function void add_word(int unsigned len, logic [OP_W-1:0] op);
			cigar_entry_t e;
			e.word = {len[WORD_W-OP_W-1:0], op};
			e.fin  = 1'b0;
			e.tail = 1'b0;
			fresh_words = {fresh_words, e};
		endfunction

		function int unsigned pending_count();
			return pending_words.size();
		endfunction

		function void note_column(logic [BASE_W-1:0] rb, logic [BASE_W-1:0] qb,
				logic first, logic last, logic empty, logic [CLIP_W-1:0] cb,
				logic [CLIP_W-1:0] ce, logic [CLIP_W-1:0] rl);
			logic         rgap;
			logic         qgap;
			logic         grow;
			logic         closes;
			int unsigned  run_max;
			int unsigned  i;
			cigar_entry_t e;
			fresh_words.delete();
			rgap    = (rb == GAP_CHAR);
			qgap    = (qb == GAP_CHAR);
			grow    = 1'b0;
			closes  = 1'b0;
			run_max = (32'd1 << RUN_COUNT_BITS_DEF) - 32'd1;
			if (empty) begin
				// An empty alignment drops any open run and reports the whole
				// read as clipped, even a read of length zero.
				clear_run();
				add_word(rl, OP_S);
				closes = 1'b1;
			end else begin
				if (first) begin
					clear_run();
					if (cb != 0)
						add_word(cb, OP_S);
				end
				if (open_run) begin
					case (open_op)
						RUN_M:   grow = !rgap && !qgap;
						RUN_I:   grow = rgap;
						default: grow = qgap;
					endcase
				end
				if (grow) begin
					if (open_len < run_max)
						open_len++;
				end else begin
					if (open_run)
						add_word(open_len, {2'b00, open_op});
					open_op  = rgap ? RUN_I : (qgap ? RUN_D : RUN_M);
					open_len = 1;
					open_run = 1'b1;
				end
				if (last) begin
					add_word(open_len, {2'b00, open_op});
					// The trailing clip is skipped when it would be zero or negative.
					if (int'(rl) > int'(ce) + 1)
						add_word(int'(rl) - int'(ce) - 1, OP_S);
					clear_run();
					closes = 1'b1;
				end
			end
			for (i = 0; i < fresh_words.size(); i++) begin
				e      = fresh_words[i];
				e.tail = (i == fresh_words.size() - 1);
				e.fin  = closes && e.tail;
				pending_words = {pending_words, e};
			end
		endfunction

		task report(string what, logic [WORD_W-1:0] exp_val, logic [WORD_W-1:0] got_val);
			$display("mismatch on %s at %0t: expected 0x%08h, got 0x%08h",
				what, $realtime, exp_val, got_val);
			mismatches++;
		endtask

		task check_word(logic [WORD_W-1:0] word, logic fin, logic tail);
			cigar_entry_t e;
			if (pending_words.size() == 0) begin
				report("unexpected word", '0, word);
			end else begin
				e = pending_words.pop_front();
				if (e.word !== word)
					report("cigar_word", e.word, word);
				if (e.fin !== fin)
					report("final_word", e.fin, fin);
				if (e.tail !== tail)
					report("last_of_item", e.tail, tail);
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BASE_W-1:0] ref_base;
	logic [BASE_W-1:0] query_base;
	logic              first_column;
	logic              last_column;
	logic              empty_alignment;
	logic [CLIP_W-1:0] clip_begin;
	logic [CLIP_W-1:0] clip_end;
	logic [CLIP_W-1:0] total_read_length;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] cigar_word;
	logic              final_word;
	logic              last_of_item;

	cigar_scoreboard ledger = new();

	// Shared controls between the stimulus and the receiver. While idle_on is
	// set both sides insert random bursts of idle cycles; hold_request asks the
	// receiver for one long hold-off.
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned columns_sent = 0;
	int unsigned cycle_count = 0;

	alignment_cigar_run_encoder_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.ref_base          (ref_base),
		.query_base        (query_base),
		.first_column      (first_column),
		.last_column       (last_column),
		.empty_alignment   (empty_alignment),
		.clip_begin        (clip_begin),
		.clip_end          (clip_end),
		.total_read_length (total_read_length),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cigar_word        (cigar_word),
		.final_word        (final_word),
		.last_of_item      (last_of_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge. A column accepted at the
	// same edge as a word leaves is noted first, so its words are queued before
	// any check that could need them.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			ledger.note_column(ref_base, query_base, first_column, last_column,
				empty_alignment, clip_begin, clip_end, total_read_length);
		if (arst_n && out_valid && out_ready)
			ledger.check_word(cigar_word, final_word, last_of_item);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver. Each falling edge gets exactly one update of out_ready. The
	// long hold-off and the random stall bursts share one countdown.
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 15);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Any byte except the gap character.
	function automatic logic [BASE_W-1:0] pick_base();
		logic [BASE_W-1:0] b;
		b = BASE_W'($urandom_range(0, 255));
		if (b == GAP_CHAR)
			b = 8'h4E;
		return b;
	endfunction

	// Offers one column and returns at the falling edge after it was taken.
	// It is entered at a falling edge; an optional idle burst comes first.
	task automatic offer_column(logic [BASE_W-1:0] rb, logic [BASE_W-1:0] qb,
			logic first, logic last, logic empty, logic [CLIP_W-1:0] cb,
			logic [CLIP_W-1:0] ce, logic [CLIP_W-1:0] rl);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		ref_base          <= rb;
		query_base        <= qb;
		first_column      <= first;
		last_column       <= last;
		empty_alignment   <= empty;
		clip_begin        <= cb;
		clip_end          <= ce;
		total_read_length <= rl;
		in_valid          <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		columns_sent++;
		@(negedge clk);
	endtask

	task automatic send_column(col_kind_t kind, logic first, logic last, logic empty,
			logic [CLIP_W-1:0] cb, logic [CLIP_W-1:0] ce, logic [CLIP_W-1:0] rl);
		logic [BASE_W-1:0] rb;
		logic [BASE_W-1:0] qb;
		rb = (kind == COL_INS || kind == COL_BOTH_GAP) ? GAP_CHAR : pick_base();
		qb = (kind == COL_DEL || kind == COL_BOTH_GAP) ? GAP_CHAR : pick_base();
		offer_column(rb, qb, first, last, empty, cb, ce, rl);
	endtask

	// Matches are the most common column shape; insertions, deletions and gaps on both bytes are equally likely.
	function automatic col_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return COL_MATCH;
		else if (r < 6)
			return COL_INS;
		else if (r < 8)
			return COL_DEL;
		return COL_BOTH_GAP;
	endfunction

	// A well-formed alignment of ncols columns made of runs of random shape.
	// Mostly short runs, now and then a long one. When closed is clear the
	// alignment is cut off before its last column.
	task automatic send_alignment(int unsigned ncols, bit closed);
		col_kind_t         kind;
		int unsigned       left;
		int unsigned       k;
		logic [CLIP_W-1:0] cb;
		logic [CLIP_W-1:0] ce;
		logic [CLIP_W-1:0] rl;
		cb   = ($urandom_range(0, 3) == 0) ? '0 : CLIP_W'($urandom);
		ce   = CLIP_W'($urandom);
		rl   = CLIP_W'($urandom);
		// Keep the trailing clip near zero fairly often.
		if ($urandom_range(0, 2) == 0)
			rl = ce + CLIP_W'($urandom_range(0, 3));
		kind = COL_MATCH;
		left = 0;
		for (k = 0; k < ncols; k++) begin
			if (left == 0) begin
				kind = pick_kind();
				left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 4);
			end
			left--;
			send_column(kind, k == 0, closed && k == ncols - 1, 1'b0,
				(k == 0) ? cb : CLIP_W'($urandom),
				(k == ncols - 1) ? ce : CLIP_W'($urandom),
				(k == ncols - 1) ? rl : CLIP_W'($urandom));
		end
	endtask

	// Holds the input idle until every expected word has come out. At least
	// one falling edge passes, so the next column is driven in a later step.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (ledger.pending_count() != 0);
	endtask

	initial begin : stimulus
		int unsigned k;
		int unsigned pick;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		ref_base          = '0;
		query_base        = '0;
		first_column      = 1'b0;
		last_column       = 1'b0;
		empty_alignment   = 1'b0;
		clip_begin        = '0;
		clip_end          = '0;
		total_read_length = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty alignments: a zero-length read still gives one clip word, and
		// the bases and column flags are ignored.
		offer_column(8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// One-column alignment with the widest clips: three words at once.
		offer_column(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);
		// Gap handling: both-gap columns open insertions, extend insertions and
		// deletions, but close a match. The negative trailing clip is dropped.
		offer_column(GAP_CHAR, GAP_CHAR, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(GAP_CHAR, GAP_CHAR, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'h41, GAP_CHAR, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(GAP_CHAR, GAP_CHAR, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'h41, 8'h43, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(GAP_CHAR, GAP_CHAR, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(GAP_CHAR, 8'h54, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'h0000);
		// Trailing clip of exactly zero is not sent.
		offer_column(8'h41, 8'h43, 1'b1, 1'b1, 1'b0, 16'h0005, 16'h0009, 16'h000A);
		// Columns with no first column open a run of their own; a later first
		// column throws that run away without a word.
		offer_column(8'h47, 8'h47, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'h41, 8'h43, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(GAP_CHAR, GAP_CHAR, 1'b1, 1'b0, 1'b0, 16'h0003, 16'h0000, 16'h0000);
		offer_column(8'h41, GAP_CHAR, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0002, 16'h000A);
		// An empty alignment in the middle of an open run discards the run.
		offer_column(8'h54, 8'h41, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'h54, 8'h41, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
		offer_column(8'h54, 8'h41, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0007);

		// Back pressure: the receiver stops for a long while and the sender
		// keeps pushing columns, most of which close a run, so the encoder's word
		// queue fills and in_ready has to drop.
		idle_on      = 1'b0;
		hold_request = 1'b1;
		for (k = 0; k < 40; k++)
			send_column(col_kind_t'(1 + k % 3), k == 0, k == 39, 1'b0,
				16'h0011, 16'h0020, 16'h0100);
		idle_on = 1'b1;
		wait_for_drain();

		// Random part: mostly complete alignments, the rest stray columns,
		// empty alignments and alignments that are cut off.
		while (columns_sent < 190) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_alignment($urandom_range(1, 12), 1'b1);
			end else if (pick == 7) begin
				send_column(pick_kind(), 1'($urandom), 1'($urandom), 1'b1,
					CLIP_W'($urandom), CLIP_W'($urandom), CLIP_W'($urandom));
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 3))
					send_column(pick_kind(), 1'b0, 1'b0, 1'b0,
						CLIP_W'($urandom), CLIP_W'($urandom), CLIP_W'($urandom));
			end else begin
				send_alignment($urandom_range(1, 6), 1'b0);
			end
		end

		// Closing stretch at full rate on both sides.
		idle_on = 1'b0;
		while (columns_sent < 225)
			send_alignment($urandom_range(1, 10), 1'b1);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (ledger.mismatches == 0 && ledger.pending_count() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
